@@ rtl/core/utf8_decode_cp1252_fallback_unit_defines.svh @@
// assertion macros shared by the decoder rtl
`ifndef UTF8_DECODE_CP1252_FALLBACK_UNIT_DEFINES_SVH
`define UTF8_DECODE_CP1252_FALLBACK_UNIT_DEFINES_SVH

`ifndef SYNTHESIS
// check that is masked while reset is high
`define U8D_ASSERT(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);
// check that also holds around reset
`define U8D_ASSERT_RST(label, prop, msg) \
   label: assert property (@(posedge clock) prop) else $error(msg);
`else
`define U8D_ASSERT(label, prop, msg)
`define U8D_ASSERT_RST(label, prop, msg)
`endif

`endif

@@ rtl/core/u8d_pkg.sv @@
`default_nettype none

package u8d_pkg;

   localparam int unsigned CP_W = 21;
   localparam int unsigned LEN_W = 3;

   localparam logic [CP_W-1:0] REPLACEMENT_CHAR = 21'h00FFFD;

   localparam logic [LEN_W-1:0] LEN_ONE = 3'd1;
   localparam logic [LEN_W-1:0] LEN_TWO = 3'd2;
   localparam logic [LEN_W-1:0] LEN_THREE = 3'd3;
   localparam logic [LEN_W-1:0] LEN_FOUR = 3'd4;

   // what kind of sequence the lead byte and its trailers form
   typedef enum logic [2:0] {
      KIND_ASCII,
      KIND_CP1252,
      KIND_SEQ2,
      KIND_SEQ3,
      KIND_SEQ4,
      KIND_BAD
   } kind_type;

   // classification result passed from the check stage to the assembly stage
   typedef struct packed {
      kind_type         kind;
      logic [LEN_W-1:0] len;
   } class_type;

   // cp1252 upper control range 0x80..0x9f
   function automatic logic [15:0] cp1252_map(input logic [4:0] idx);
      logic [15:0] val;
      case (idx)
         5'd0:    val = 16'h20AC;
         5'd1:    val = 16'h0081;
         5'd2:    val = 16'h201A;
         5'd3:    val = 16'h0192;
         5'd4:    val = 16'h201E;
         5'd5:    val = 16'h2026;
         5'd6:    val = 16'h2020;
         5'd7:    val = 16'h2021;
         5'd8:    val = 16'h02C6;
         5'd9:    val = 16'h2030;
         5'd10:   val = 16'h0160;
         5'd11:   val = 16'h2039;
         5'd12:   val = 16'h0152;
         5'd13:   val = 16'h008D;
         5'd14:   val = 16'h017D;
         5'd15:   val = 16'h008F;
         5'd16:   val = 16'h0090;
         5'd17:   val = 16'h2018;
         5'd18:   val = 16'h2019;
         5'd19:   val = 16'h201C;
         5'd20:   val = 16'h201D;
         5'd21:   val = 16'h2022;
         5'd22:   val = 16'h2013;
         5'd23:   val = 16'h2014;
         5'd24:   val = 16'h02DC;
         5'd25:   val = 16'h2122;
         5'd26:   val = 16'h0161;
         5'd27:   val = 16'h203A;
         5'd28:   val = 16'h0153;
         5'd29:   val = 16'h009D;
         5'd30:   val = 16'h017E;
         5'd31:   val = 16'h0178;
         default: val = 16'h0000;
      endcase
      return val;
   endfunction

endpackage

`default_nettype wire

@@ rtl/core/utf8_decode_cp1252_fallback_unit.sv @@
// utf-8 decoder with cp1252 fallback, three register stages
// an accepted request passes the input, check and output registers in order before rsp_tvalid
// throughput: one transaction per cycle while the output is not stalled, set by the input, check and assembly stages
// a stalled output holds each stage in place without loss or repeat
// reset: synchronous, active high, clears all stage valid bits
`default_nettype none

`include "utf8_decode_cp1252_fallback_unit_defines.svh"

module utf8_decode_cp1252_fallback_unit (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output      logic        req_tready,
   // lead_byte[7:0], second_byte[15:8], third_byte[23:16], fourth_byte[31:24],
   // bytes_available[34:32], zero fill[39:35]
   input  wire logic [39:0] req_tdata,
   output      logic        rsp_tvalid,
   input  wire logic        rsp_tready,
   // code_point[20:0], consumed_length[23:21]
   output      logic [23:0] rsp_tdata
);

   // stage 1: input register
   logic                 s1_valid_ff;
   logic                 s1_valid_in;
   logic [7:0]           s1_b0_ff;
   logic [7:0]           s1_b1_ff;
   logic [7:0]           s1_b2_ff;
   logic [7:0]           s1_b3_ff;
   logic [2:0]           s1_avail_ff;
   // stage 2: classified bytes
   logic                 s2_valid_ff;
   logic                 s2_valid_in;
   logic [7:0]           s2_b0_ff;
   logic [7:0]           s2_b1_ff;
   logic [7:0]           s2_b2_ff;
   logic [7:0]           s2_b3_ff;
   u8d_pkg::class_type   s2_class_ff;
   u8d_pkg::class_type   s2_class_in;
   // stage 3: output register
   logic                 s3_valid_ff;
   logic                 s3_valid_in;
   logic [20:0]          s3_cp_ff;
   logic [20:0]          s3_cp_in;
   logic [2:0]           s3_len_ff;

   logic                 s1_ready;
   logic                 s2_ready;
   logic                 s3_ready;

   // each stage moves when it is empty or its successor moves
   assign s3_ready   = !s3_valid_ff || rsp_tready;
   assign s2_ready   = !s2_valid_ff || s3_ready;
   assign s1_ready   = !s1_valid_ff || s2_ready;
   assign req_tready = s1_ready;

   assign s1_valid_in = s1_ready ? req_tvalid : s1_valid_ff;
   assign s2_valid_in = s2_ready ? s1_valid_ff : s2_valid_ff;
   assign s3_valid_in = s3_ready ? s2_valid_ff : s3_valid_ff;

   // valid bits
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
         s3_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
         s2_valid_ff <= s2_valid_in;
         s3_valid_ff <= s3_valid_in;
      end
   end

   // capture an accepted transaction
   always_ff @(posedge clock) begin
      if (s1_ready && req_tvalid) begin
         s1_b0_ff    <= req_tdata[7:0];
         s1_b1_ff    <= req_tdata[15:8];
         s1_b2_ff    <= req_tdata[23:16];
         s1_b3_ff    <= req_tdata[31:24];
         s1_avail_ff <= req_tdata[34:32];
      end
   end

   // sequence checks
   u8d_classify u_classify (
      .lead_byte       (s1_b0_ff),
      .second_byte     (s1_b1_ff),
      .third_byte      (s1_b2_ff),
      .fourth_byte     (s1_b3_ff),
      .bytes_available (s1_avail_ff),
      .class_out       (s2_class_in)
   );

   always_ff @(posedge clock) begin
      if (s2_ready && s1_valid_ff) begin
         s2_b0_ff    <= s1_b0_ff;
         s2_b1_ff    <= s1_b1_ff;
         s2_b2_ff    <= s1_b2_ff;
         s2_b3_ff    <= s1_b3_ff;
         s2_class_ff <= s2_class_in;
      end
   end

   // code point assembly
   always_comb begin
      case (s2_class_ff.kind)
         u8d_pkg::KIND_ASCII:  s3_cp_in = {13'd0, s2_b0_ff};
         u8d_pkg::KIND_CP1252: s3_cp_in = {5'd0, u8d_pkg::cp1252_map(s2_b0_ff[4:0])};
         u8d_pkg::KIND_SEQ2:   s3_cp_in = {10'd0, s2_b0_ff[4:0], s2_b1_ff[5:0]};
         u8d_pkg::KIND_SEQ3:   s3_cp_in = {5'd0, s2_b0_ff[3:0], s2_b1_ff[5:0],
                                           s2_b2_ff[5:0]};
         u8d_pkg::KIND_SEQ4:   s3_cp_in = {s2_b0_ff[2:0], s2_b1_ff[5:0],
                                           s2_b2_ff[5:0], s2_b3_ff[5:0]};
         default:              s3_cp_in = u8d_pkg::REPLACEMENT_CHAR;
      endcase
   end

   always_ff @(posedge clock) begin
      if (s3_ready && s2_valid_ff) begin
         s3_cp_ff  <= s3_cp_in;
         s3_len_ff <= s2_class_ff.len;
      end
   end

   assign rsp_tvalid = s3_valid_ff;
   assign rsp_tdata  = {s3_len_ff, s3_cp_ff};

   // checks
   `U8D_ASSERT_RST(a_reset_empty, reset |=> !rsp_tvalid, "output valid right after reset")
   `U8D_ASSERT(a_len_range,
      rsp_tvalid |-> (s3_len_ff != 3'd0) && (s3_len_ff <= u8d_pkg::LEN_FOUR),
      "consumed length out of range")
   `U8D_ASSERT(a_seq2_range,
      (rsp_tvalid && (s3_len_ff == u8d_pkg::LEN_TWO)) |->
         (s3_cp_ff >= 21'h80) && (s3_cp_ff < 21'h800),
      "two-byte result outside its range")
   `U8D_ASSERT(a_seq4_range,
      (rsp_tvalid && (s3_len_ff == u8d_pkg::LEN_FOUR)) |->
         (s3_cp_ff >= 21'h10000) && (s3_cp_ff <= 21'h10FFFF),
      "four-byte result outside its range")
   `U8D_ASSERT(a_s2_hold,
      (s2_valid_ff && !s2_ready) |=> s2_valid_ff && $stable(s2_class_ff) && $stable(s2_b0_ff),
      "stage two changed while stalled")

endmodule

`default_nettype wire

@@ rtl/core/u8d_classify.sv @@
`default_nettype none

module u8d_classify (
   input  wire logic [7:0]          lead_byte,
   input  wire logic [7:0]          second_byte,
   input  wire logic [7:0]          third_byte,
   input  wire logic [7:0]          fourth_byte,
   input  wire logic [2:0]          bytes_available,
   output u8d_pkg::class_type       class_out
);

   logic avail_ge2;
   logic avail_ge3;
   logic avail_ge4;
   logic cont1;
   logic cont2;
   logic cont3;
   logic ok3;
   logic ok4;

   // zero available acts like one, five to seven like four
   assign avail_ge2 = (bytes_available >= 3'd2);
   assign avail_ge3 = (bytes_available >= 3'd3);
   assign avail_ge4 = (bytes_available >= 3'd4);

   // trailing bytes must look like 10xxxxxx
   assign cont1 = (second_byte[7:6] == 2'b10);
   assign cont2 = (third_byte[7:6] == 2'b10);
   assign cont3 = (fourth_byte[7:6] == 2'b10);

   // overlong and range checks on the second byte, plus availability and continuation of the later bytes
   assign ok3 = ((lead_byte != 8'hE0) || (second_byte >= 8'hA0)) && avail_ge3 && cont2;
   assign ok4 = ((lead_byte != 8'hF0) || (second_byte >= 8'h90)) &&
                ((lead_byte != 8'hF4) || (second_byte <= 8'h8F)) &&
                avail_ge4 && cont2 && cont3;

   // pick the sequence kind and its length
   always_comb begin
      class_out.kind = u8d_pkg::KIND_BAD;
      class_out.len  = u8d_pkg::LEN_ONE;
      if (lead_byte < 8'h80) begin
         class_out.kind = u8d_pkg::KIND_ASCII;
      end else if (lead_byte < 8'hA0) begin
         class_out.kind = u8d_pkg::KIND_CP1252;
      end else if ((lead_byte >= 8'hC2) && (lead_byte <= 8'hF4) && avail_ge2 && cont1) begin
         if (lead_byte < 8'hE0) begin
            class_out.kind = u8d_pkg::KIND_SEQ2;
            class_out.len  = u8d_pkg::LEN_TWO;
         end else if (lead_byte < 8'hF0) begin
            if (ok3) begin
               class_out.kind = u8d_pkg::KIND_SEQ3;
               class_out.len  = u8d_pkg::LEN_THREE;
            end
         end else if (ok4) begin
            class_out.kind = u8d_pkg::KIND_SEQ4;
            class_out.len  = u8d_pkg::LEN_FOUR;
         end
      end
   end

endmodule

`default_nettype wire
